>>> src/shortest_job_first_scheduler_core_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each expands to a labelled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef SHORTEST_JOB_FIRST_SCHEDULER_CORE_MACROS_SVH
`define SHORTEST_JOB_FIRST_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset
`define SJFS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge
`define SJFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SJFS_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SJFS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> src/sjfs_pkg.sv
`default_nettype none

package sjfs_pkg;

  // Table size
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // Field widths
  localparam int ID_W     = 8;
  localparam int BURST_W  = 16;
  localparam int TIME_W   = 32;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_ADD      = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // One queued command
  typedef struct packed {
    cmd_t                cmd;
    logic [ID_W-1:0]     id;
    logic [BURST_W-1:0]  burst;
  } item_t;

endpackage

`default_nettype wire

>>> src/sjfs_front.sv
`default_nettype none
`include "shortest_job_first_scheduler_core_macros.svh"

// Front end: takes commands and queues them for the back end
module sjfs_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [sjfs_pkg::ID_W-1:0]     in_task_id,
  input  wire logic [sjfs_pkg::BURST_W-1:0]  in_burst_length,
  output logic                               q_valid,
  output sjfs_pkg::item_t                    q_item,
  input  wire logic                          q_pop
);

  sjfs_pkg::item_t             fifo_r [sjfs_pkg::QDEPTH];
  logic [sjfs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sjfs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sjfs_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        push;
  logic                        pop;
  sjfs_pkg::item_t             new_item;

  // Classify the incoming command
  always_comb begin
    new_item.cmd   = sjfs_pkg::cmd_t'(in_command);
    new_item.id    = in_task_id;
    new_item.burst = in_burst_length;
  end

  assign busy    = (count_r == sjfs_pkg::QCNT_W'(sjfs_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = fifo_r[rd_ptr_r];

  // Pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sjfs_pkg::QPTR_W'(sjfs_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sjfs_pkg::QPTR_W'(sjfs_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

  `SJFS_ASSERT_RST(a_cnt_bound, clk, rst_n, count_r <= sjfs_pkg::QCNT_W'(sjfs_pkg::QDEPTH), "queue count above depth")
  `SJFS_ASSERT_RST(a_cnt_grow, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "queue count did not grow on transfer")

endmodule

`default_nettype wire

>>> src/sjfs_back.sv
`default_nettype none
`include "shortest_job_first_scheduler_core_macros.svh"

// Back end: scans the task table, executes add or dispatch, reports
module sjfs_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire sjfs_pkg::item_t               q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [sjfs_pkg::ID_W-1:0]          out_chosen_id,
  output logic [sjfs_pkg::BURST_W-1:0]       out_chosen_burst,
  output logic [sjfs_pkg::TIME_W-1:0]        out_elapsed_time,
  output logic [sjfs_pkg::TIME_W-1:0]        out_dispatch_time
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_LAST   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_REPORT = 5'b10000
  } bstate_t;

  localparam int SW = sjfs_pkg::SLOT_W;
  localparam int TW = sjfs_pkg::TIME_W;

  bstate_t                          state_r, state_nxt;
  sjfs_pkg::item_t                  cur_r;
  logic [SW-1:0]                    scan_idx_r;
  logic                             scan_last;

  // Slot storage
  logic [sjfs_pkg::TASK_SLOTS-1:0]  valid_r;
  logic [sjfs_pkg::ID_W-1:0]        mem_id    [sjfs_pkg::TASK_SLOTS];
  logic [sjfs_pkg::BURST_W-1:0]     mem_burst [sjfs_pkg::TASK_SLOTS];
  logic [sjfs_pkg::ID_W-1:0]        rd_id_r;
  logic [sjfs_pkg::BURST_W-1:0]     rd_burst_r;
  logic                             mem_we;

  // Compare stage, registered alongside the slot read data
  logic                             cmp_en_r;
  logic [SW-1:0]                    cmp_idx_r;
  logic                             cmp_vld_r;
  logic                             best_found_r;
  logic [SW-1:0]                    best_idx_r;
  logic [sjfs_pkg::ID_W-1:0]        best_id_r;
  logic [sjfs_pkg::BURST_W-1:0]     best_burst_r;
  logic                             free_found_r;
  logic [SW-1:0]                    free_idx_r;
  logic                             take_best;
  logic                             take_free;

  // Counters
  logic [TW-1:0]                    time_r;
  logic [TW-1:0]                    sw_r;
  logic [TW:0]                      time_sum;
  logic [TW+1:0]                    disp_sum;
  logic [TW-1:0]                    disp_val;

  // Result registers
  logic                             out_valid_r;
  sjfs_pkg::status_t                out_status_r;
  logic [sjfs_pkg::ID_W-1:0]        out_id_r;
  logic [sjfs_pkg::BURST_W-1:0]     out_burst_r;
  logic [TW-1:0]                    out_elapsed_r;
  logic [TW-1:0]                    out_disp_r;

  logic                             is_add;

  assign scan_last = (scan_idx_r == SW'(sjfs_pkg::TASK_SLOTS - 1));
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign is_add    = (cur_r.cmd == sjfs_pkg::CMD_ADD);
  assign mem_we    = (state_r == ST_COMMIT) && is_add && free_found_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_last) state_nxt = ST_LAST;
      ST_LAST:   state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Running minimum of {burst, id}; strict less keeps the lowest slot on a tie
  assign take_best = cmp_en_r && cmp_vld_r &&
                     (!best_found_r || (rd_burst_r < best_burst_r) ||
                      ((rd_burst_r == best_burst_r) && (rd_id_r < best_id_r)));
  // Lowest free slot
  assign take_free = cmp_en_r && !cmp_vld_r && !free_found_r;

  // Saturating time update
  assign time_sum = {1'b0, time_r} + {{(TW + 1 - sjfs_pkg::BURST_W){1'b0}}, best_burst_r};

  // Dispatcher time from the committed counters
  assign disp_sum = {2'b00, time_r} + {2'b00, sw_r} - (TW + 2)'(1);
  always_comb begin
    if (sw_r == '0) begin
      disp_val = '0;
    end else if (disp_sum[TW+1:TW] != 2'b00) begin
      disp_val = '1;
    end else begin
      disp_val = disp_sum[TW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      time_r       <= '0;
      sw_r         <= '0;
      cmp_en_r     <= 1'b0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_en_r    <= (state_r == ST_SCAN);
      out_valid_r <= (state_r == ST_REPORT);
      if (q_pop) begin
        best_found_r <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (take_best) best_found_r <= 1'b1;
        if (take_free) free_found_r <= 1'b1;
      end
      if (state_r == ST_COMMIT) begin
        if (is_add) begin
          if (free_found_r) valid_r[free_idx_r] <= 1'b1;
        end else if (best_found_r) begin
          valid_r[best_idx_r] <= 1'b0;
          time_r <= time_sum[TW] ? '1 : time_sum[TW-1:0];
          if (sw_r != '1) sw_r <= sw_r + 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r      <= q_item;
      scan_idx_r <= '0;
    end else if ((state_r == ST_SCAN) && !scan_last) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (state_r == ST_SCAN) begin
      cmp_idx_r <= scan_idx_r;
      cmp_vld_r <= valid_r[scan_idx_r];
    end
    if (take_best) begin
      best_idx_r   <= cmp_idx_r;
      best_id_r    <= rd_id_r;
      best_burst_r <= rd_burst_r;
    end
    if (take_free) begin
      free_idx_r <= cmp_idx_r;
    end
    if (state_r == ST_COMMIT) begin
      if (is_add) begin
        out_status_r <= free_found_r ? sjfs_pkg::STAT_OK : sjfs_pkg::STAT_FULL;
        out_id_r     <= '0;
        out_burst_r  <= '0;
      end else if (best_found_r) begin
        out_status_r <= sjfs_pkg::STAT_OK;
        out_id_r     <= best_id_r;
        out_burst_r  <= best_burst_r;
      end else begin
        out_status_r <= sjfs_pkg::STAT_EMPTY;
        out_id_r     <= '0;
        out_burst_r  <= '0;
      end
    end
    if (state_r == ST_REPORT) begin
      out_elapsed_r <= time_r;
      out_disp_r    <= disp_val;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[free_idx_r]    <= cur_r.id;
      mem_burst[free_idx_r] <= cur_r.burst;
    end
    rd_id_r    <= mem_id[scan_idx_r];
    rd_burst_r <= mem_burst[scan_idx_r];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_chosen_id     = out_id_r;
  assign out_chosen_burst  = out_burst_r;
  assign out_elapsed_time  = out_elapsed_r;
  assign out_dispatch_time = out_disp_r;

  `SJFS_ASSERT_RST(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r, "result strobe held for more than one cycle")
  `SJFS_ASSERT_RST(a_one_slot_change, clk, rst_n, 1'b1 |=> ($countones(valid_r ^ $past(valid_r)) <= 1), "more than one slot changed in a cycle")
  `SJFS_ASSERT_RST(a_full_means_full, clk, rst_n, (out_valid_r && (out_status_r == sjfs_pkg::STAT_FULL)) |-> (&valid_r), "full reported with a free slot")

endmodule

`default_nettype wire

>>> src/shortest_job_first_scheduler_core.sv
`default_nettype none

// Shortest-job-first scheduler. A command is taken when start is high and
// busy is low; its result appears on the out_ ports for exactly one cycle,
// marked by out_valid, and cannot be held off by the receiver. Each command
// scans the whole task table through a slot memory with one read port, one
// slot per cycle, then passes the ST_LAST, ST_COMMIT and ST_REPORT states;
// the back end takes no new command until it is back in ST_IDLE, so a
// command that waits in the queue waits for the one ahead. A two-entry
// command queue sits in front of the back end; busy rises only when it is
// full, so up to two commands can be handed over while one is executing.
module shortest_job_first_scheduler_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [sjfs_pkg::ID_W-1:0]     in_task_id,
  input  wire logic [sjfs_pkg::BURST_W-1:0]  in_burst_length,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [sjfs_pkg::ID_W-1:0]          out_chosen_id,
  output logic [sjfs_pkg::BURST_W-1:0]       out_chosen_burst,
  output logic [sjfs_pkg::TIME_W-1:0]        out_elapsed_time,
  output logic [sjfs_pkg::TIME_W-1:0]        out_dispatch_time
);

  logic             q_valid;
  logic             q_pop;
  sjfs_pkg::item_t  q_item;

  // Command intake and queue
  sjfs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_task_id      (in_task_id),
    .in_burst_length (in_burst_length),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Table scan, execution and reporting
  sjfs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_chosen_id     (out_chosen_id),
    .out_chosen_burst  (out_chosen_burst),
    .out_elapsed_time  (out_elapsed_time),
    .out_dispatch_time (out_dispatch_time)
  );

endmodule

`default_nettype wire
